>>> rtl/core/tps_pkg.sv
`default_nettype none

package tps_pkg;

  // Sample and result widths fixed by the channel definitions.
  localparam int SAMPLE_W = 16;
  localparam int VAR_W    = 32;
  localparam int DEV_W    = 16;

endpackage

`default_nettype wire

>>> rtl/core/tps_if.sv
`default_nettype none

interface tps_in_if
  import tps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface tps_out_if
  import tps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mean;
  logic [VAR_W-1:0]    variance;
  logic [DEV_W-1:0]    deviation;
  logic [SAMPLE_W-1:0] minimum;
  logic [SAMPLE_W-1:0] maximum;
  logic [SAMPLE_W-1:0] median;

  modport source (output valid, output mean, output variance, output deviation,
                  output minimum, output maximum, output median, input ready);
  modport sink   (input valid, input mean, input variance, input deviation,
                  input minimum, input maximum, input median, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tps_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tps_divider
  import tps_pkg::*;
#(
  parameter int N_W = 43,
  parameter int D_W = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quo
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] quo_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] den_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  assign trial = {rem_r, quo_r[N_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[N_W-2:0], ge};
      rem_r <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> rtl/core/tps_sqrt.sv
`default_nettype none

// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
module tps_sqrt
  import tps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAR_W-1:0] value,
  output logic             done,
  output logic [DEV_W-1:0] root
);

  localparam int STEPS = VAR_W / 2;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int W     = VAR_W + 1;

  logic [W-1:0]  v_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  b_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          fin_r;
  logic          done_r;
  logic [DEV_W-1:0] root_r;
  logic [W-1:0]  rb;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= W'(value);
      r_r <= '0;
      b_r <= W'(1) << (VAR_W - 2);
    end else if (busy_r) begin
      if (v_r >= rb) begin
        v_r <= v_r - rb;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
    if (fin_r) begin
      root_r <= (v_r > r_r) ? DEV_W'(r_r + W'(1)) : DEV_W'(r_r);
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

>>> rtl/core/temporal_pixel_statistics.sv
`default_nettype none

// Channel  Direction  Transaction contents
// in_if    sink       sample (16 bits, zero means missing), last (closes the set)
// out_if   source     mean, variance, deviation, minimum, maximum, median
//
// Samples are taken one per cycle while the block is loading. The transaction with
// last set starts the evaluation, during which in_if.ready is low. The evaluation
// is serial: one shared divider serves the mean and the variance, the sample memory
// has a single read port, and the median comes from a rank search for N > 2 stored
// samples, or from the sum of the samples for one or two.
// Reset is synchronous and active low; the sample memory is not cleared.
// A result waiting on out_if does not stop the next set from loading.
module temporal_pixel_statistics
  import tps_pkg::*;
#(
  parameter int MAX_FRAMES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tps_in_if.sink    in_if,
  tps_out_if.source out_if
);

  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int Q_W    = 2 * SAMPLE_W + CNT_W;
  localparam int NUM_W  = 2 * SUM_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int DIV_NW = NUM_W + 1;
  localparam int DIV_DW = DEN_W + 1;

  typedef enum logic [14:0] {
    ST_LOAD   = 15'b000000000000001,
    ST_MEAN   = 15'b000000000000010,
    ST_MEAN_W = 15'b000000000000100,
    ST_SQ     = 15'b000000000001000,
    ST_MUL    = 15'b000000000010000,
    ST_SUB    = 15'b000000000100000,
    ST_VAR    = 15'b000000001000000,
    ST_VAR_W  = 15'b000000010000000,
    ST_SQRT_W = 15'b000000100000000,
    ST_MCAND  = 15'b000001000000000,
    ST_MCWAIT = 15'b000010000000000,
    ST_MSWEEP = 15'b000100000000000,
    ST_M2     = 15'b001000000000000,
    ST_EMIT   = 15'b010000000000000,
    ST_SQRT   = 15'b100000000000000
  } state_t;

  state_t state_r;

  // Running statistics of the set being loaded.
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    nz_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] min_r;
  logic [SAMPLE_W-1:0] max_r;

  // Sweep control.
  logic [CNT_W-1:0] j_r;
  logic [CNT_W-1:0] i_r;
  logic             pend_r;
  logic             sqv_r;
  logic [CNT_W-1:0] lt_r;
  logic [CNT_W-1:0] eq_r;

  // Working results.
  logic [SAMPLE_W-1:0]   mean_r;
  logic [2*SAMPLE_W-1:0] sq_r;
  logic [Q_W-1:0]        q_r;
  logic [NUM_W-1:0]      cq_r;
  logic [NUM_W-1:0]      ss_r;
  logic [NUM_W-1:0]      num_r;
  logic [DEN_W-1:0]      den_r;
  logic [VAR_W-1:0]      var_r;
  logic [DEV_W-1:0]      dev_r;
  logic [SAMPLE_W-1:0]   cand_r;
  logic [SAMPLE_W:0]     msum_r;
  logic [SAMPLE_W-1:0]   med_r;

  // Output register.
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] o_mean_r;
  logic [VAR_W-1:0]    o_var_r;
  logic [DEV_W-1:0]    o_dev_r;
  logic [SAMPLE_W-1:0] o_min_r;
  logic [SAMPLE_W-1:0] o_max_r;
  logic [SAMPLE_W-1:0] o_med_r;

  // Sample memory: one write port, one registered read port.
  logic [SAMPLE_W-1:0] mem [MAX_FRAMES];
  logic [SAMPLE_W-1:0] mem_q;
  logic [ADDR_W-1:0]   rd_addr;

  logic                accept;
  logic                room;
  logic                issue;
  logic                sweep_end;
  logic [SAMPLE_W-1:0] rv;
  logic [CNT_W:0]      half_w;
  logic [CNT_W-1:0]    k_w;
  logic                found;
  logic                emit_go;
  logic [SAMPLE_W:0]   mrnd;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;
  logic              sq_start;
  logic              sq_done;
  logic [DEV_W-1:0]  sq_root;

  assign in_if.ready = (state_r == ST_LOAD);
  assign accept      = in_if.valid && in_if.ready;
  assign room        = cnt_r < CNT_W'(MAX_FRAMES);

  // A sweep issues one read per cycle; the data come back in the following cycle.
  assign issue     = j_r < cnt_r;
  assign sweep_end = (j_r == cnt_r) && !pend_r;
  assign rd_addr   = (state_r == ST_MCAND) ? i_r[ADDR_W-1:0] : j_r[ADDR_W-1:0];

  // Missing samples take the rounded mean for the median.
  assign rv = (mem_q == '0) ? mean_r : mem_q;

  // The median sits at index min(N-1, ceil(N/2)) of the sorted samples; a
  // candidate holds it when no more than that many lie below it and enough equal it.
  assign half_w = ({1'b0, cnt_r} + (CNT_W + 1)'(1)) >> 1;
  assign k_w    = (half_w >= {1'b0, cnt_r}) ? cnt_r - CNT_W'(1) : half_w[CNT_W-1:0];
  assign found  = (lt_r <= k_w) && ({1'b0, k_w} < ({1'b0, lt_r} + {1'b0, eq_r}));
  assign mrnd   = msum_r + (SAMPLE_W + 1)'(1);

  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  // The divider serves both the rounded mean and the rounded variance.
  assign div_start = (state_r == ST_MEAN && nz_r != '0) || (state_r == ST_VAR);
  always_comb begin
    if (state_r == ST_VAR) begin
      div_num = {num_r, 1'b0} + DIV_NW'(den_r);
      div_den = {den_r, 1'b0};
    end else begin
      div_num = DIV_NW'({sum_r, 1'b0}) + DIV_NW'(nz_r);
      div_den = DIV_DW'({nz_r, 1'b0});
    end
  end
  assign sq_start = (state_r == ST_SQRT);

  tps_divider #(
    .N_W (DIV_NW),
    .D_W (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  tps_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (var_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_if.sample;
    end
    mem_q <= mem[rd_addr];
  end

  // Control: state, running statistics and sweep counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      nz_r        <= '0;
      sum_r       <= '0;
      min_r       <= '1;
      max_r       <= '0;
      j_r         <= '0;
      i_r         <= '0;
      pend_r      <= 1'b0;
      sqv_r       <= 1'b0;
      lt_r        <= '0;
      eq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt_r <= cnt_r + CNT_W'(1);
              if (in_if.sample != '0) begin
                nz_r  <= nz_r + CNT_W'(1);
                sum_r <= sum_r + SUM_W'(in_if.sample);
                if (in_if.sample < min_r) min_r <= in_if.sample;
                if (in_if.sample > max_r) max_r <= in_if.sample;
              end
            end
            if (in_if.last) state_r <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          state_r <= (nz_r == '0) ? ST_EMIT : ST_MEAN_W;
        end
        ST_MEAN_W: begin
          if (div_done) begin
            state_r <= ST_SQ;
            j_r     <= '0;
            pend_r  <= 1'b0;
            sqv_r   <= 1'b0;
          end
        end
        ST_SQ: begin
          if (issue) j_r <= j_r + CNT_W'(1);
          pend_r <= issue;
          sqv_r  <= pend_r;
          if (sweep_end && !sqv_r) state_r <= ST_MUL;
        end
        ST_MUL:    state_r <= ST_SUB;
        ST_SUB:    state_r <= ST_VAR;
        ST_VAR:    state_r <= ST_VAR_W;
        ST_VAR_W: begin
          if (div_done) state_r <= ST_SQRT;
        end
        ST_SQRT:   state_r <= ST_SQRT_W;
        ST_SQRT_W: begin
          if (sq_done) begin
            j_r    <= '0;
            i_r    <= '0;
            pend_r <= 1'b0;
            state_r <= (cnt_r > CNT_W'(2)) ? ST_MCAND : ST_M2;
          end
        end
        ST_MCAND:  state_r <= ST_MCWAIT;
        ST_MCWAIT: begin
          j_r     <= '0;
          lt_r    <= '0;
          eq_r    <= '0;
          pend_r  <= 1'b0;
          state_r <= ST_MSWEEP;
        end
        ST_MSWEEP: begin
          if (issue) j_r <= j_r + CNT_W'(1);
          pend_r <= issue;
          if (pend_r) begin
            if (rv < cand_r)  lt_r <= lt_r + CNT_W'(1);
            if (rv == cand_r) eq_r <= eq_r + CNT_W'(1);
          end
          if (sweep_end) begin
            if (found) begin
              state_r <= ST_EMIT;
            end else begin
              i_r     <= i_r + CNT_W'(1);
              state_r <= ST_MCAND;
            end
          end
        end
        ST_M2: begin
          if (issue) j_r <= j_r + CNT_W'(1);
          pend_r <= issue;
          if (sweep_end) state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            cnt_r   <= '0;
            nz_r    <= '0;
            sum_r   <= '0;
            min_r   <= '1;
            max_r   <= '0;
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MEAN: begin
        if (nz_r == '0) begin
          mean_r <= '0;
          var_r  <= '0;
          dev_r  <= '0;
          med_r  <= '0;
        end
        q_r <= '0;
      end
      ST_MEAN_W: begin
        if (div_done) mean_r <= div_quo[SAMPLE_W-1:0];
      end
      ST_SQ: begin
        sq_r <= (2 * SAMPLE_W)'(mem_q) * (2 * SAMPLE_W)'(mem_q);
        if (sqv_r) q_r <= q_r + Q_W'(sq_r);
      end
      ST_MUL: begin
        cq_r <= NUM_W'(nz_r) * NUM_W'(q_r);
        ss_r <= NUM_W'(sum_r) * NUM_W'(sum_r);
      end
      ST_SUB: begin
        num_r <= cq_r - ss_r;
        den_r <= DEN_W'(nz_r) * DEN_W'(cnt_r);
      end
      ST_VAR_W: begin
        if (div_done) var_r <= div_quo[VAR_W-1:0];
      end
      ST_SQRT_W: begin
        if (sq_done) dev_r <= sq_root;
        msum_r <= '0;
      end
      ST_MCWAIT: cand_r <= rv;
      ST_MSWEEP: begin
        if (sweep_end && found) med_r <= cand_r;
      end
      ST_M2: begin
        if (pend_r) msum_r <= msum_r + (SAMPLE_W + 1)'(rv);
        if (sweep_end) begin
          med_r <= (cnt_r == CNT_W'(1)) ? msum_r[SAMPLE_W-1:0] : mrnd[SAMPLE_W:1];
        end
      end
      default: begin
      end
    endcase

    if (emit_go) begin
      o_mean_r <= mean_r;
      o_var_r  <= var_r;
      o_dev_r  <= dev_r;
      o_min_r  <= (nz_r == '0) ? '0 : min_r;
      o_max_r  <= max_r;
      o_med_r  <= med_r;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.mean      = o_mean_r;
  assign out_if.variance  = o_var_r;
  assign out_if.deviation = o_dev_r;
  assign out_if.minimum   = o_min_r;
  assign out_if.maximum   = o_max_r;
  assign out_if.median    = o_med_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(MAX_FRAMES)) && (nz_r <= cnt_r))
    else $error("sample counts out of range");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MEAN_W || state_r == ST_VAR_W))
    else $error("divider finished outside a wait state");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_valid_r && state_r == ST_LOAD && cnt_r == '0))
    else $error("result not presented after emit");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |=> $stable(cnt_r) || ($past(emit_go) && cnt_r == '0))
    else $error("sample count moved during evaluation");
`endif

endmodule

`default_nettype wire
